[rtl/mcs_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Maximum clique search package
// Shared widths, constants, state type and control structures.
// ---------------------------------------------------------------------------
package mcs_pkg;

  localparam int ROW_SLOTS        = 16;
  localparam int VID_W            = 4;
  localparam int ROW_W            = 16;
  localparam int CNT_W            = 5;
  localparam int MAX_VERTICES_DEF = 16;
  localparam int IN_DATA_W        = 24;
  localparam int OUT_DATA_W       = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
  } comb_cmd_t;

endpackage
`default_nettype wire

[rtl/max_clique_search.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Maximum clique search
// Loads an adjacency matrix row by row and reports the largest clique.
// ---------------------------------------------------------------------------
// Rows arrive on the slave stream, one transfer per row, and are taken one
// per cycle while the block is idle. A transfer with tlast set stores its row
// and starts the search; no further rows are taken until the result has been
// placed in the output register. Candidate subsets are tried from the vertex
// count down to two, each in lexicographic order. Testing one candidate
// reads its rows one at a time from the single read port of the row store,
// passing through ST_READ and ST_CHECK for each row, up to k-1 rows for a
// subset of size k, and a row that misses moves on to the next candidate.
// The result is one transfer on the master stream; while the receiver stalls
// it is held, and rows without tlast are still accepted. Reset empties the
// output register, returns to idle and sets the vertex count to 16. The row
// store is not cleared: every row used by a search must have been written.
// ---------------------------------------------------------------------------
module max_clique_search
  import mcs_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  vertex_count_wr,
  input  wire logic [CNT_W-1:0]      vertex_count,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // row_index [3:0], row_bits [19:4], zero fill
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic                  s_tlast,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // clique_size [4:0], clique_members [20:5], zero fill
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  localparam int ROW_DEPTH = (MAX_VERTICES < ROW_SLOTS) ? MAX_VERTICES : ROW_SLOTS;
  localparam int AW        = $clog2(ROW_DEPTH);

  state_t           state, state_next;
  comb_cmd_t        cmd;
  logic [CNT_W-1:0] vcount;
  logic [CNT_W-1:0] n;
  logic [VID_W-1:0] pos, pos_next;
  logic [CNT_W-1:0] k;
  logic [VID_W-1:0] addr;
  logic [ROW_W-1:0] low_mask;
  logic [ROW_W-1:0] set_mask;
  logic [ROW_W-1:0] rdata;
  logic             s_accept;
  logic             row_we;
  logic             res_load;
  logic             res_zero;
  logic [CNT_W-1:0] res_size;
  logic [ROW_W-1:0] res_mask;
  logic             out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= CNT_W'(16);
    end else if (vertex_count_wr) begin
      vcount <= vertex_count;
    end
  end

  assign n = (vcount > CNT_W'(ROW_DEPTH)) ? CNT_W'(ROW_DEPTH) : vcount;

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign row_we   = s_accept && ({1'b0, s_tdata[VID_W-1:0]} < CNT_W'(ROW_DEPTH));

  mcs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROW_DEPTH)
  ) u_rows (
    .clk   (clk),
    .we    (row_we),
    .waddr (s_tdata[AW-1:0]),
    .wdata (s_tdata[VID_W +: ROW_W]),
    .raddr (addr[AW-1:0]),
    .rdata (rdata)
  );

  mcs_comb u_comb (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .n        (n),
    .pos      (pos),
    .k        (k),
    .addr     (addr),
    .low_mask (low_mask),
    .set_mask (set_mask)
  );

  always_comb begin
    state_next = state;
    pos_next   = pos;
    cmd        = '0;
    res_load   = 1'b0;
    res_zero   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_accept && s_tlast) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.start  = 1'b1;
        pos_next   = VID_W'(1);
        state_next = ST_READ;
      end
      ST_READ: begin
        if (k < CNT_W'(2)) begin
          res_load   = 1'b1;
          res_zero   = 1'b1;
          state_next = ST_DONE;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((rdata & low_mask) == low_mask) begin
          if ({1'b0, pos} == k - CNT_W'(1)) begin
            res_load   = 1'b1;
            state_next = ST_DONE;
          end else begin
            pos_next   = pos + VID_W'(1);
            state_next = ST_READ;
          end
        end else begin
          cmd.step   = 1'b1;
          pos_next   = VID_W'(1);
          state_next = ST_READ;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pos      <= VID_W'(1);
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_size <= res_zero ? '0 : k;
      res_mask <= res_zero ? '0 : set_mask;
    end
    if (out_load) begin
      m_tdata <= {{(OUT_DATA_W - CNT_W - ROW_W){1'b0}}, res_mask, res_size};
    end
  end

endmodule
`default_nettype wire

[rtl/mcs_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ---------------------------------------------------------------------------
module mcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/mcs_comb.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Combination generator
// Holds the current candidate subset as a sorted vertex tuple and steps it
// through lexicographic order, dropping the subset size when exhausted.
// ---------------------------------------------------------------------------
module mcs_comb
  import mcs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire comb_cmd_t        cmd,
  input  wire logic [CNT_W-1:0] n,
  input  wire logic [VID_W-1:0] pos,
  output logic      [CNT_W-1:0] k,
  output logic      [VID_W-1:0] addr,
  output logic      [ROW_W-1:0] low_mask,
  output logic      [ROW_W-1:0] set_mask
);

  logic [VID_W-1:0] pick [ROW_SLOTS];
  logic [VID_W-1:0] pick_next [ROW_SLOTS];
  logic [CNT_W-1:0] k_next;
  logic             sel_found;
  logic [VID_W-1:0] sel_p;
  logic [VID_W-1:0] sel_val;
  logic [CNT_W:0]   lim_p;

  always_comb begin
    sel_found = 1'b0;
    sel_p     = '0;
    lim_p     = '0;
    for (int p = 0; p < ROW_SLOTS; p++) begin
      lim_p = {1'b0, n} - {1'b0, k} + (CNT_W+1)'(p);
      if ((CNT_W'(p) < k) && ({2'b00, pick[p]} < lim_p)) begin
        sel_found = 1'b1;
        sel_p     = VID_W'(p);
      end
    end
  end

  assign sel_val = pick[sel_p];

  always_comb begin
    k_next = k;
    for (int q = 0; q < ROW_SLOTS; q++) begin
      pick_next[q] = pick[q];
    end
    if (cmd.start) begin
      k_next = n;
      for (int q = 0; q < ROW_SLOTS; q++) begin
        pick_next[q] = VID_W'(q);
      end
    end else if (cmd.step) begin
      if (sel_found) begin
        for (int q = 0; q < ROW_SLOTS; q++) begin
          if (VID_W'(q) >= sel_p) begin
            pick_next[q] = VID_W'({1'b0, sel_val} + CNT_W'(q) - {1'b0, sel_p} + 5'd1);
          end
        end
      end else begin
        k_next = k - 5'd1;
        for (int q = 0; q < ROW_SLOTS; q++) begin
          pick_next[q] = VID_W'(q);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else begin
      k <= k_next;
    end
    for (int q = 0; q < ROW_SLOTS; q++) begin
      pick[q] <= pick_next[q];
    end
  end

  assign addr = pick[pos];

  always_comb begin
    low_mask = '0;
    set_mask = '0;
    for (int b = 0; b < ROW_SLOTS; b++) begin
      if (VID_W'(b) < pos) begin
        low_mask = low_mask | (ROW_W'(1) << pick[b]);
      end
      if (CNT_W'(b) < k) begin
        set_mask = set_mask | (ROW_W'(1) << pick[b]);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/mcs_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Maximum clique search port checker
// Watches the top-level ports and flags broken handshakes and results that cannot be right.
// ---------------------------------------------------------------------------
module mcs_checker
  import mcs_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  logic [CNT_W-1:0] size;
  logic [ROW_W-1:0] members;

  assign size    = m_tdata[CNT_W-1:0];
  assign members = m_tdata[CNT_W +: ROW_W];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result transfer changed or was dropped.");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Result offered straight after reset.");

  a_no_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> size != CNT_W'(1))
    else $error("Clique of one vertex reported.");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones(members) == int'(size))
    else $error("Member mask does not match clique size.");

endmodule

bind max_clique_search mcs_checker u_mcs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
